>>> hdl/spv_pkg.sv
// Shared types and constants for the short-name path validator.
// No dependencies; compile first.
package spv_pkg;

	// Character classes produced by the front end, consumed by the checker
	typedef enum logic [2:0] {
		CLS_NAME,
		CLS_DOT,
		CLS_SLASH,
		CLS_END,
		CLS_BAD
	} cls_t;

	// One queue write from the front end
	typedef struct packed {
		logic valid;
		cls_t cls;
	} q_item_t;

	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);

	localparam logic [3:0] BASE_MAX = 4'd8;
	localparam logic [2:0] EXT_MAX  = 3'd3;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [7:0] SYM_SET [16] = '{
		8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
		8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26
	};

endpackage

>>> hdl/spv_ch_if.sv
// Input channel: one path byte per transfer.
// Stand-alone; no package use.
interface spv_ch_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

>>> hdl/spv_ok_if.sv
// Output channel: one path verdict per transfer.
// Stand-alone; no package use.
interface spv_ok_if;
	logic valid;
	logic ready;
	logic path_ok;

	modport source (output valid, output path_ok, input ready);
	modport sink   (input valid, input path_ok, output ready);
endinterface

>>> hdl/spv_classify.sv
// Front end: takes path bytes and classifies each one into a queue entry.
// Uses spv_pkg and spv_ch_if.
module spv_classify (
	spv_ch_if.sink           chars,
	input  logic             q_full,
	output spv_pkg::q_item_t push
);
	import spv_pkg::*;

	logic is_alnum;
	logic is_sym;

	assign is_alnum = (chars.ch >= 8'h41 && chars.ch <= 8'h5A) ||
	                  (chars.ch >= 8'h61 && chars.ch <= 8'h7A) ||
	                  (chars.ch >= 8'h30 && chars.ch <= 8'h39);

	always_comb begin
		is_sym = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (chars.ch == SYM_SET[i])
				is_sym = 1'b1;
		end
	end

	always_comb begin
		push.valid = chars.valid && !q_full;
		if (chars.ch == CH_END)
			push.cls = CLS_END;
		else if (chars.ch == CH_SLASH)
			push.cls = CLS_SLASH;
		else if (chars.ch == CH_DOT)
			push.cls = CLS_DOT;
		else if (is_alnum || is_sym)
			push.cls = CLS_NAME;
		else
			push.cls = CLS_BAD;
	end

	assign chars.ready = !q_full;

endmodule

>>> hdl/spv_queue.sv
// Short class queue between front end and checker.
// Uses spv_pkg.
module spv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  spv_pkg::q_item_t push,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output spv_pkg::cls_t    head_cls
);
	import spv_pkg::*;

	cls_t             mem_q [QDEPTH];
	logic [QPW-1:0]   wptr_q;
	logic [QPW-1:0]   rptr_q;
	logic [QPW:0]     count_q;

	assign full       = (count_q == (QPW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cls   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wptr_q] <= push.cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push.valid && !pop)
				count_q <= count_q + 1'b1;
			else if (!push.valid && pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hdl/spv_check.sv
// Back end: per-part 8.3 checks on classified bytes, verdict output register.
// Uses spv_pkg and spv_ok_if.
module spv_check #(
	parameter int MAX_PART = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  spv_pkg::cls_t head_cls,
	output logic          pop,
	spv_ok_if.source      verdict
);
	import spv_pkg::*;

	localparam int             PCW    = $clog2(MAX_PART + 1);
	localparam logic [PCW-1:0] PC_MAX = PCW'(MAX_PART);

	logic           failed_q;
	logic           started_q;
	logic           dot_q;
	logic [3:0]     base_q;
	logic [2:0]     ext_q;
	logic [PCW-1:0] pc_q;
	logic           ok_valid_q;
	logic           ok_q;

	logic close_fail;
	logic pc_sat;

	// part counter saturates at the limit; reaching it means the part is too long
	assign pc_sat     = (pc_q == PC_MAX);
	assign close_fail = (pc_q != '0) &&
	                    (base_q == '0 || base_q > BASE_MAX || ext_q > EXT_MAX || pc_sat);

	// a pending verdict blocks only the next end marker
	assign pop = head_valid &&
	             (head_cls != CLS_END || !ok_valid_q || verdict.ready);

	assign verdict.valid   = ok_valid_q;
	assign verdict.path_ok = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q   <= 1'b0;
			started_q  <= 1'b0;
			dot_q      <= 1'b0;
			base_q     <= '0;
			ext_q      <= '0;
			pc_q       <= '0;
			ok_valid_q <= 1'b0;
		end else begin
			if (verdict.ready && !(pop && head_cls == CLS_END))
				ok_valid_q <= 1'b0;
			if (pop) begin
				case (head_cls)
					CLS_END: begin
						ok_valid_q <= 1'b1;
						failed_q   <= 1'b0;
						started_q  <= 1'b0;
						dot_q      <= 1'b0;
						base_q     <= '0;
						ext_q      <= '0;
						pc_q       <= '0;
					end
					CLS_SLASH: begin
						started_q <= 1'b1;
						failed_q  <= failed_q | close_fail;
						dot_q     <= 1'b0;
						base_q    <= '0;
						ext_q     <= '0;
						pc_q      <= '0;
					end
					CLS_DOT: begin
						started_q <= 1'b1;
						if (!pc_sat)
							pc_q <= pc_q + 1'b1;
						if (dot_q)
							failed_q <= 1'b1;
						dot_q <= 1'b1;
					end
					CLS_BAD: begin
						started_q <= 1'b1;
						if (!pc_sat)
							pc_q <= pc_q + 1'b1;
						failed_q <= 1'b1;
					end
					CLS_NAME: begin
						started_q <= 1'b1;
						if (!pc_sat)
							pc_q <= pc_q + 1'b1;
						if (dot_q) begin
							if (ext_q <= EXT_MAX)
								ext_q <= ext_q + 1'b1;
						end else if (base_q <= BASE_MAX) begin
							base_q <= base_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// verdict data only loads with its valid
	always_ff @(posedge clk) begin
		if (pop && head_cls == CLS_END)
			ok_q <= started_q && !failed_q && !close_fail;
	end

endmodule

>>> hdl/short_name_path_validator_top.sv
// Top level of the 8.3 short-name path validator: front end, queue, checker.
// Uses spv_pkg, spv_ch_if, spv_ok_if, spv_classify, spv_queue, spv_check.
//
//  channel   dir  payload          one transfer carries
//  chars     in   ch [7:0]         next path byte; 0 ends path, '/' splits parts
//  verdict   out  path_ok [0:0]    1 if path nonempty and all parts are 8.3 names
//
// One byte per cycle sustained while no verdict is stalled. After its zero byte
// is transferred, a verdict passes the class queue, then the output register.
// The byte rate is set by the checker update on the queue head.
// arst_n clears all path state, the queue pointers and the verdict valid flag.
// A stalled verdict holds only the next zero byte at the queue head; the
// four-entry queue keeps taking bytes until it fills, then chars.ready drops.
module short_name_path_validator_top #(
	parameter int MAX_PART = 64
) (
	input logic      clk,
	input logic      arst_n,
	spv_ch_if.sink   chars,
	spv_ok_if.source verdict
);
	import spv_pkg::*;

	q_item_t push;
	logic    q_full;
	logic    q_pop;
	logic    q_valid;
	cls_t    q_cls;

	// classify each incoming byte
	spv_classify u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push)
	);

	// decouples byte intake from checking
	spv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cls   (q_cls)
	);

	// part checks and verdict register
	spv_check #(
		.MAX_PART (MAX_PART)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_cls   (q_cls),
		.pop        (q_pop),
		.verdict    (verdict)
	);

`ifndef SYNTH
	// an accepted byte is in the queue next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready |=> q_valid)
		else $error("accepted byte missing from queue");

	// popping an end marker always produces a verdict
	a_end_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_cls == CLS_END |=> verdict.valid)
		else $error("end marker popped without verdict");

	// a stalled verdict is never overwritten by the next end marker
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && !verdict.ready && q_valid && q_cls == CLS_END |-> !q_pop)
		else $error("pending verdict overwritten");
`endif

endmodule

>>> bench/spv_path_checker.sv
// Checker for the short-name path validator: predicts each verdict from the byte stream.
// It compares each verdict with the expected one and counts mismatches.
// Depends on spv_pkg; it samples both channels at the rising clock edge.
module spv_path_checker #(
	parameter int MAX_PART = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ch_valid,
	input  logic       ch_ready,
	input  logic [7:0] ch,
	input  logic       ok_valid,
	input  logic       ok_ready,
	input  logic       path_ok,
	output int         mismatch_count,
	output int         verdicts_seen,
	output int         verdicts_ok,
	output int         pending
);
	import spv_pkg::*;

	// Predicted path state
	logic       failed;
	logic       started;
	logic       dot_seen;
	logic [3:0] base_n;
	logic [2:0] ext_n;
	logic [6:0] part_n;

	logic expected_verdicts[$];

	// Letters, digits and $ % ' - _ @ ~ ` ! ( ) { } ^ # &
	function automatic logic legal_char(input logic [7:0] c);
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
				(c >= 8'h30 && c <= 8'h39))
			return 1'b1;
		case (c)
			8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
			8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_part();
		dot_seen = 1'b0;
		base_n   = '0;
		ext_n    = '0;
		part_n   = '0;
	endtask

	// Judge the open part, if any
	task automatic close_part();
		if (part_n != 0) begin
			if (base_n == 0 || base_n > BASE_MAX || ext_n > EXT_MAX ||
					int'(part_n) >= MAX_PART)
				failed = 1'b1;
		end
		clear_part();
	endtask

	task automatic apply_path_byte(input logic [7:0] c);
		if (c == CH_END) begin
			close_part();
			expected_verdicts.push_back(started && !failed);
			failed  = 1'b0;
			started = 1'b0;
		end else begin
			started = 1'b1;
			if (c == CH_SLASH) begin
				close_part();
			end else begin
				if (part_n != 7'd127)
					part_n++;
				if (c == CH_DOT) begin
					if (dot_seen)
						failed = 1'b1;
					dot_seen = 1'b1;
				end else if (!legal_char(c)) begin
					failed = 1'b1;
				end else if (dot_seen) begin
					if (ext_n < EXT_MAX + 1)
						ext_n++;
				end else if (base_n < BASE_MAX + 1) begin
					base_n++;
				end
			end
		end
	endtask

	task automatic report(input string msg);
		$display("%0t: verdict mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic want;
		if (!arst_n) begin
			failed  = 1'b0;
			started = 1'b0;
			clear_part();
			expected_verdicts.delete();
			mismatch_count = 0;
			verdicts_seen  = 0;
			verdicts_ok    = 0;
			pending        = 0;
		end else begin
			if (ch_valid && ch_ready)
				apply_path_byte(ch);
			if (ok_valid && ok_ready) begin
				if (expected_verdicts.size() == 0) begin
					report($sformatf("verdict %b with no path pending", path_ok));
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_seen++;
					if (want)
						verdicts_ok++;
					if (path_ok !== want)
						report($sformatf("path_ok %b, expected %b", path_ok, want));
				end
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

>>> bench/tb_short_name_path_validator_top.sv
// Testbench top for the short-name path validator: clock, reset, path stimulus, verdict.
// Depends on spv_pkg, spv_ch_if, spv_ok_if, the block and spv_path_checker.
module tb_short_name_path_validator_top;
	import spv_pkg::*;

	localparam int MAX_PART        = 64;
	localparam int BYTES_PER_PHASE = 550;   // three pacing phases, ~1650 bytes total
	localparam int DRAIN_CYCLES    = 10;    // post-drain watch for stray verdicts

	logic clk;
	logic arst_n;

	spv_ch_if chars_if ();
	spv_ok_if verdict_if ();

	// Percent of cycles in which each side holds off
	int send_idle_pct;
	int recv_idle_pct;

	int bytes_sent;
	int paths_sent;

	int mismatch_count;
	int verdicts_seen;
	int verdicts_ok;
	int pending;

	// Bytes of the path being built, terminating zero included
	logic [7:0] path_bytes[$];

	short_name_path_validator_top #(
		.MAX_PART(MAX_PART)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.verdict(verdict_if)
	);

	spv_path_checker #(
		.MAX_PART(MAX_PART)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.ch_valid      (chars_if.valid),
		.ch_ready      (chars_if.ready),
		.ch            (chars_if.ch),
		.ok_valid      (verdict_if.valid),
		.ok_ready      (verdict_if.ready),
		.path_ok       (verdict_if.path_ok),
		.mismatch_count(mismatch_count),
		.verdicts_seen (verdicts_seen),
		.verdicts_ok   (verdicts_ok),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#400000;
		$display("short_name_path_validator_top verification failed");
		$finish;
	end

	// Verdict back-pressure, redrawn every cycle
	always @(negedge clk) begin
		verdict_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// One byte transfer. Entered and left at a falling edge; valid stays high on exit
	// so back-to-back bytes need no extra NBA in the same step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= b;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_path();
		foreach (path_bytes[i])
			send_byte(path_bytes[i]);
		paths_sent++;
	endtask

	// Any character that may stand in a short name (dot excluded)
	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(77);
		if (r < 26)
			return 8'(8'h41 + r);
		if (r < 52)
			return 8'(8'h61 + r - 26);
		if (r < 62)
			return 8'(8'h30 + r - 52);
		return SYM_SET[r - 62];
	endfunction

	task automatic add_name(input int base_len, input int ext_len, input bit with_dot);
		repeat (base_len)
			path_bytes.push_back(name_char());
		if (with_dot)
			path_bytes.push_back(CH_DOT);
		repeat (ext_len)
			path_bytes.push_back(name_char());
	endtask

	// One part: mostly well-formed 8.3 names, the rest broken in one way each
	task automatic add_part();
		int         mode;
		int         start;
		int         pos;
		logic [7:0] junk;
		mode  = $urandom_range(99);
		start = path_bytes.size();
		if (mode < 70) begin
			add_name($urandom_range(1, 8), $urandom_range(0, 3), 1'b0);
			// dot only when an extension follows, or now and then a bare trailing dot
			if (path_bytes.size() - start > 1 && $urandom_range(1))
				path_bytes.insert(start + $urandom_range(1, path_bytes.size() - start), CH_DOT);
		end else if (mode < 75) begin
			add_name($urandom_range(9, 10), $urandom_range(0, 3), 1'($urandom_range(1)));
		end else if (mode < 80) begin
			add_name($urandom_range(1, 8), $urandom_range(4, 5), 1'b1);
		end else if (mode < 84) begin
			add_name(0, $urandom_range(1, 3), 1'b1);    // no base name
		end else if (mode < 88) begin
			add_name($urandom_range(1, 4), $urandom_range(0, 2), 1'b1);
			path_bytes.push_back(CH_DOT);                // second dot
			path_bytes.push_back(name_char());
		end else if (mode < 93) begin
			// valid shape with one arbitrary byte dropped in
			add_name($urandom_range(1, 8), $urandom_range(0, 3), 1'b1);
			junk = 8'($urandom_range(1, 255));
			if (junk == CH_SLASH)
				junk = 8'hAF;
			pos = start + $urandom_range(0, path_bytes.size() - start - 1);
			path_bytes[pos] = junk;
		end else if (mode < 97) begin
			add_name(0, 0, 1'b1);                        // "." part
			if ($urandom_range(1))
				path_bytes.push_back(CH_DOT);            // ".." part
		end else begin
			// long part, reaching past the part limit and the counter ceiling
			add_name($urandom_range(13, 140), 0, 1'b0);
		end
	endtask

	task automatic build_random_path();
		int kind;
		int parts;
		path_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 4) begin
			// empty path
		end else if (kind < 8) begin
			repeat ($urandom_range(1, 4))
				path_bytes.push_back(CH_SLASH);
		end else begin
			parts = $urandom_range(1, 4);
			if ($urandom_range(3) == 0)
				path_bytes.push_back(CH_SLASH);
			for (int p = 0; p < parts; p++) begin
				if (p != 0)
					repeat ($urandom_range(1, 3))
						path_bytes.push_back(CH_SLASH);
				add_part();
			end
			if ($urandom_range(4) == 0)
				path_bytes.push_back(CH_SLASH);
		end
		path_bytes.push_back(CH_END);
	endtask

	initial begin
		chars_if.valid   = 1'b0;
		chars_if.ch      = '0;
		verdict_if.ready = 1'b0;
		arst_n           = 1'b0;
		send_idle_pct    = 12;
		recv_idle_pct    = 81;
		bytes_sent       = 0;
		paths_sent       = 0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed paths: empty, slashes only, dot parts, character range edges, bad bytes,
		// leading and trailing separators
		path_bytes = '{CH_END};
		send_path();
		path_bytes = '{CH_SLASH, CH_SLASH, CH_END};
		send_path();
		path_bytes = '{CH_DOT, CH_END};
		send_path();
		path_bytes = '{CH_DOT, CH_DOT, CH_END};
		send_path();
		path_bytes = '{8'h41, 8'h7A, 8'h30, 8'h39, CH_DOT, 8'h7E, 8'h60, CH_END};
		send_path();
		path_bytes = '{8'hFF, CH_END};
		send_path();
		path_bytes = '{8'h01, CH_END};
		send_path();
		path_bytes = '{CH_SLASH, 8'h61, CH_SLASH, CH_END};
		send_path();

		// Random paths under three pacing modes: slow sink, slow source, full rate
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (bytes_sent < (phase + 1) * BYTES_PER_PHASE) begin
				build_random_path();
				send_path();
			end
		end
		chars_if.valid <= 1'b0;

		// Drain outstanding verdicts, then watch a little longer for strays
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d path bytes forming %0d paths across three pacing modes.",
			bytes_sent, paths_sent);
		$display("Checked %0d verdicts, %0d accepting, %0d mismatches.",
			verdicts_seen, verdicts_ok, mismatch_count);
		if (mismatch_count == 0 && pending == 0) begin
			$display("short_name_path_validator_top verification clean");
		end else begin
			$display("short_name_path_validator_top verification failed");
		end
		$finish;
	end

endmodule

>>> short_name_path_validator_top.f
hdl/spv_pkg.sv
hdl/spv_ch_if.sv
hdl/spv_ok_if.sv
hdl/spv_classify.sv
hdl/spv_queue.sv
hdl/spv_check.sv
hdl/short_name_path_validator_top.sv
bench/spv_path_checker.sv
bench/tb_short_name_path_validator_top.sv
